@@ src/slmo_pkg.sv @@
// slmo_pkg: shared types and constants for the sorted list merge offset match block
// no dependencies; used by slmo_front, slmo_fifo, slmo_back and the top level
package slmo_pkg;

  // b store sizing
  localparam int unsigned B_DEPTH = 1024;
  localparam int unsigned B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int unsigned B_CW    = $clog2(B_DEPTH + 1);
  localparam logic [B_CW-1:0] B_FULL = B_CW'(B_DEPTH);

  // command queue sizing
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned DATA_W = 32;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_REWIND = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  // one queued command: data is the b value for append, the target for query
  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] match_value;
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } back_state_t;

  typedef struct packed {
    logic            scanning;
    logic [B_CW-1:0] b_count;
    logic [B_CW-1:0] scan_pos;
  } back_status_t;

endpackage

@@ src/sorted_list_merge_offset_match.sv @@
// sorted_list_merge_offset_match: merge-join of an ascending b list with a query stream
// a query passes the command queue, then the back end scans b; a match loads the result register
// clear, append and rewind need no scan; a query holds the back end in the single scan loop
//   over the b store read port (one entry per cycle, held while a match waits for out_ready)
// reset: synchronous active low; fill count, scan pointer, queue and config clear at once,
//   the b store itself is not cleared (only entries below the fill count are read)
module sorted_list_merge_offset_match (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slmo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slmo_pkg::DATA_W-1:0]         cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic [slmo_pkg::DATA_W-1:0]         in_value,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [slmo_pkg::DATA_W-1:0]         out_match_value
);

  // front to queue
  logic                   push;
  slmo_pkg::cmd_t         push_cmd;
  logic                   fifo_full;

  // queue to back
  logic                   cmd_valid;
  logic                   cmd_pop;
  slmo_pkg::cmd_t         cmd;

  slmo_pkg::back_status_t back_status;

  // front: config registers, target and output value per query, one transfer per cycle while the queue is not full
  slmo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  // short queue lets the front keep taking items while the back scans
  slmo_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop_valid (cmd_valid),
    .pop       (cmd_pop),
    .pop_cmd   (cmd)
  );

  // back: b store, forward-only scan, result register
  slmo_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_value (out_match_value),
    .status          (back_status)
  );

  // scan pointer never passes the fill count
  assert property (@(posedge clk) disable iff (!rst_n)
    back_status.scan_pos <= back_status.b_count)
    else $error("scan pointer beyond fill count");

  // fill count stays within the store
  assert property (@(posedge clk) disable iff (!rst_n)
    back_status.b_count <= slmo_pkg::B_FULL)
    else $error("fill count beyond store depth");

  // a new result only comes out of a scan step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(back_status.scanning))
    else $error("result raised outside a scan");

  // while scanning the pointer is on a written entry
  assert property (@(posedge clk) disable iff (!rst_n)
    back_status.scanning |-> (back_status.scan_pos < back_status.b_count))
    else $error("scan on an unwritten entry");

endmodule

@@ src/slmo_front.sv @@
// slmo_front: configuration registers and input classification
// depends on slmo_pkg; turns an input item into a queued command
module slmo_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slmo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slmo_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic [slmo_pkg::DATA_W-1:0]         in_value,
  output logic                                push,
  output slmo_pkg::cmd_t                      push_cmd,
  input  logic                                fifo_full
);

  logic [slmo_pkg::DATA_W-1:0] key_length_r, key_length_nxt;
  logic [slmo_pkg::DATA_W-1:0] gap_r, gap_nxt;
  logic [slmo_pkg::DATA_W-1:0] start_offset_r, start_offset_nxt;
  slmo_pkg::mode_t             mode;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~fifo_full;
  assign push      = in_valid & ~fifo_full;
  assign mode      = slmo_pkg::mode_t'(in_mode);

  always_comb begin
    key_length_nxt   = key_length_r;
    gap_nxt          = gap_r;
    start_offset_nxt = start_offset_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        slmo_pkg::REG_KEY_LENGTH:   key_length_nxt   = cfg_data;
        slmo_pkg::REG_GAP:          gap_nxt          = cfg_data;
        slmo_pkg::REG_START_OFFSET: start_offset_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r   <= '0;
      gap_r          <= '0;
      start_offset_r <= '0;
    end else begin
      key_length_r   <= key_length_nxt;
      gap_r          <= gap_nxt;
      start_offset_r <= start_offset_nxt;
    end
  end

  // target and output value are worked out here so the scan loop only compares
  always_comb begin
    push_cmd.mode        = mode;
    push_cmd.data        = in_value;
    push_cmd.match_value = '0;
    unique case (mode) inside
      slmo_pkg::MODE_QUERY: begin
        push_cmd.data        = in_value + key_length_r + gap_r;
        push_cmd.match_value = in_value - start_offset_r;
      end
      slmo_pkg::MODE_CLEAR, slmo_pkg::MODE_APPEND, slmo_pkg::MODE_REWIND: ;
    endcase
  end

endmodule

@@ src/slmo_fifo.sv @@
// slmo_fifo: short command queue between front and back
// depends on slmo_pkg for the command type and depth
module slmo_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slmo_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop,
  output slmo_pkg::cmd_t pop_cmd
);

  slmo_pkg::cmd_t                      entry_r [slmo_pkg::FIFO_DEPTH];
  logic [slmo_pkg::FIFO_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [slmo_pkg::FIFO_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [slmo_pkg::FIFO_CW-1:0]        cnt_r, cnt_nxt;
  logic                                do_push, do_pop;

  assign full      = (cnt_r == slmo_pkg::FIFO_CW'(slmo_pkg::FIFO_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == slmo_pkg::FIFO_AW'(slmo_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == slmo_pkg::FIFO_AW'(slmo_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ src/slmo_back.sv @@
// slmo_back: b store, fill count, scan pointer and merge scan
// depends on slmo_pkg; pops commands from slmo_fifo and drives the result register
module slmo_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  slmo_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [slmo_pkg::DATA_W-1:0]  out_match_value,
  output slmo_pkg::back_status_t       status
);

  logic [slmo_pkg::DATA_W-1:0]  b_mem [slmo_pkg::B_DEPTH];
  logic [slmo_pkg::DATA_W-1:0]  rdata_r;
  logic                         wr_en;

  slmo_pkg::back_state_t        state_r, state_nxt;
  logic [slmo_pkg::B_CW-1:0]    b_count_r, b_count_nxt;
  logic [slmo_pkg::B_CW-1:0]    scan_pos_r, scan_pos_nxt;
  logic [slmo_pkg::B_CW-1:0]    scan_inc;
  logic [slmo_pkg::DATA_W-1:0]  target_r;
  logic [slmo_pkg::DATA_W-1:0]  match_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [slmo_pkg::DATA_W-1:0]  out_value_r, out_value_nxt;
  logic                         out_free;

  assign scan_inc        = scan_pos_r + 1'b1;
  assign out_free        = ~out_valid_r | out_ready;
  assign out_valid       = out_valid_r;
  assign out_match_value = out_value_r;

  assign status.scanning = (state_r == slmo_pkg::ST_SCAN);
  assign status.b_count  = b_count_r;
  assign status.scan_pos = scan_pos_r;

  always_comb begin
    state_nxt     = state_r;
    b_count_nxt   = b_count_r;
    scan_pos_nxt  = scan_pos_r;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_value_nxt = out_value_r;
    unique case (state_r)
      slmo_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.mode)
            slmo_pkg::MODE_CLEAR: begin
              b_count_nxt  = '0;
              scan_pos_nxt = '0;
            end
            slmo_pkg::MODE_APPEND: begin
              if (b_count_r < slmo_pkg::B_FULL) begin
                wr_en       = 1'b1;
                b_count_nxt = b_count_r + 1'b1;
              end
            end
            slmo_pkg::MODE_REWIND: begin
              scan_pos_nxt = '0;
            end
            slmo_pkg::MODE_QUERY: begin
              if (scan_pos_r < b_count_r) begin
                state_nxt = slmo_pkg::ST_SCAN;
              end
            end
          endcase
        end
      end
      slmo_pkg::ST_SCAN: begin
        if (rdata_r < target_r) begin
          scan_pos_nxt = scan_inc;
          if (scan_inc >= b_count_r) begin
            state_nxt = slmo_pkg::ST_IDLE;
          end
        end else if (rdata_r > target_r) begin
          state_nxt = slmo_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = match_r;
          state_nxt     = slmo_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slmo_pkg::ST_IDLE;
      b_count_r   <= '0;
      scan_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      b_count_r   <= b_count_nxt;
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    if (cmd_pop) begin
      target_r <= cmd.data;
      match_r  <= cmd.match_value;
    end
  end

  // b store: write at the fill count, read ahead at the next scan position
  always_ff @(posedge clk) begin
    if (wr_en) begin
      b_mem[b_count_r[slmo_pkg::B_AW-1:0]] <= cmd.data;
    end
    rdata_r <= b_mem[scan_pos_nxt[slmo_pkg::B_AW-1:0]];
  end

endmodule
